### sv/wavelet_scalogram_row_top_defines.svh
// ---------------------------------------------------------------------------
// wavelet scalogram row assertion macros
// shared property wrappers for the scalogram row block
// ---------------------------------------------------------------------------
`ifndef WAVELET_SCALOGRAM_ROW_TOP_DEFINES_SVH
`define WAVELET_SCALOGRAM_ROW_TOP_DEFINES_SVH

`ifndef NO_ASSERTIONS
`define WSR_ASSERT_SAME(lbl, clk, rst, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) else $error(msg);
`define WSR_ASSERT_NEXT(lbl, clk, rst, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error(msg);
`else
`define WSR_ASSERT_SAME(lbl, clk, rst, ante, cons, msg)
`define WSR_ASSERT_NEXT(lbl, clk, rst, ante, cons, msg)
`endif

`endif

### sv/wsr_pkg.sv
// ---------------------------------------------------------------------------
// wsr_pkg
// types and constants of the wavelet scalogram row block
// ---------------------------------------------------------------------------
package wsr_pkg;

  localparam int MAX_LENGTH_DEF   = 1024;
  localparam int SAMPLE_WIDTH_DEF = 16;

  localparam int CMD_W   = 1;
  localparam int IDX_W   = 10;
  localparam int VAL_W   = 16;
  localparam int FLEN_W  = 11;
  localparam int MAG_W   = 26;
  localparam int POS_W   = 10;
  localparam int FRAC_BITS = 15;

  localparam logic [FLEN_W-1:0] FLEN_RESET = 11'd1000;
  localparam logic [MAG_W-1:0]  MAG_MAX    = 26'h3FFFFFF;

  localparam logic [CMD_W-1:0] CMD_LOAD   = 1'b0;
  localparam logic [CMD_W-1:0] CMD_SAMPLE = 1'b1;

  // square root: 27 result bits over a 54 bit radicand
  localparam int ROOT_STEPS = 27;
  localparam int RAD_W      = 2 * ROOT_STEPS;
  localparam int REM_W      = ROOT_STEPS + 3;
  localparam int CNT_W      = $clog2(ROOT_STEPS);
  // ram read and multiply stages ahead of the accumulator
  localparam int DRAIN_CYCLES = 2;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_MAC,
    ST_DRAIN,
    ST_PARTS,
    ST_SQUARE,
    ST_SUM,
    ST_ROOT,
    ST_DONE
  } wsr_state_t;

  typedef struct packed {
    logic load_coef;
    logic start_sample;
    logic issue;
    logic parts;
    logic square;
    logic sum;
    logic root_step;
    logic load_out;
  } wsr_cmd_t;

  typedef struct packed {
    logic last_tap;
    logic out_free;
  } wsr_stat_t;

endpackage

### sv/wsr_channels.sv
// ---------------------------------------------------------------------------
// wsr channels
// valid/ready channel interfaces for items, results and configuration
// ---------------------------------------------------------------------------
interface wsr_item_if;
  import wsr_pkg::*;
  logic                     valid;
  logic                     ready;
  logic [CMD_W-1:0]         cmd;
  logic [IDX_W-1:0]         coef_index;
  logic signed [VAL_W-1:0]  value_real;
  logic signed [VAL_W-1:0]  value_imag;
  modport source (output valid, cmd, coef_index, value_real, value_imag, input ready);
  modport sink (input valid, cmd, coef_index, value_real, value_imag, output ready);
endinterface

interface wsr_result_if;
  import wsr_pkg::*;
  logic             valid;
  logic             ready;
  logic [MAG_W-1:0] magnitude;
  logic [POS_W-1:0] sample_position;
  logic             frame_last;
  modport source (output valid, magnitude, sample_position, frame_last, input ready);
  modport sink (input valid, magnitude, sample_position, frame_last, output ready);
endinterface

interface wsr_cfg_if;
  import wsr_pkg::*;
  logic              valid;
  logic              ready;
  logic [FLEN_W-1:0] frame_length;
  modport source (output valid, frame_length, input ready);
  modport sink (input valid, frame_length, output ready);
endinterface

### sv/wsr_ram.sv
// ---------------------------------------------------------------------------
// wsr_ram
// simple dual port ram, one write and one registered read
// ---------------------------------------------------------------------------
module wsr_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 1024
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);
  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end
endmodule

### sv/wsr_ctrl.sv
// ---------------------------------------------------------------------------
// wsr_ctrl
// sequencer for taps, magnitude and result hand-off
// ---------------------------------------------------------------------------
module wsr_ctrl (
  input  logic               clk,
  input  logic               rst,
  input  logic               in_valid,
  input  logic               in_is_sample,
  input  wsr_pkg::wsr_stat_t stat,
  output logic               in_ready,
  output wsr_pkg::wsr_cmd_t  cmd
);
  import wsr_pkg::*;

  wsr_state_t       state, state_next;
  logic [CNT_W-1:0] cnt, cnt_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
      cnt   <= '0;
    end else begin
      state <= state_next;
      cnt   <= cnt_next;
    end
  end

  always_comb begin
    state_next = state;
    cnt_next   = cnt;
    case (state)
      ST_IDLE: begin
        if (in_valid && in_is_sample) begin
          state_next = ST_MAC;
        end
      end
      ST_MAC: begin
        if (stat.last_tap) begin
          state_next = ST_DRAIN;
          cnt_next   = '0;
        end
      end
      ST_DRAIN: begin
        if (cnt == CNT_W'(DRAIN_CYCLES - 1)) begin
          state_next = ST_PARTS;
        end else begin
          cnt_next = cnt + 1'b1;
        end
      end
      ST_PARTS:  state_next = ST_SQUARE;
      ST_SQUARE: state_next = ST_SUM;
      ST_SUM: begin
        state_next = ST_ROOT;
        cnt_next   = '0;
      end
      ST_ROOT: begin
        if (cnt == CNT_W'(ROOT_STEPS - 1)) begin
          state_next = ST_DONE;
        end else begin
          cnt_next = cnt + 1'b1;
        end
      end
      ST_DONE: begin
        if (stat.out_free) begin
          state_next = ST_IDLE;
        end
      end
      default: state_next = ST_IDLE;
    endcase
  end

  always_comb begin
    in_ready = 1'b0;
    cmd      = '0;
    case (state)
      ST_IDLE: begin
        in_ready         = 1'b1;
        cmd.load_coef    = in_valid && !in_is_sample;
        cmd.start_sample = in_valid && in_is_sample;
      end
      ST_MAC:    cmd.issue     = 1'b1;
      ST_DRAIN:  cmd           = '0;
      ST_PARTS:  cmd.parts     = 1'b1;
      ST_SQUARE: cmd.square    = 1'b1;
      ST_SUM:    cmd.sum       = 1'b1;
      ST_ROOT:   cmd.root_step = 1'b1;
      ST_DONE:   cmd.load_out  = stat.out_free;
      default:   cmd           = '0;
    endcase
  end
endmodule

### sv/wsr_datapath.sv
// ---------------------------------------------------------------------------
// wsr_datapath
// coefficient and history rams, complex mac, magnitude and result register
// ---------------------------------------------------------------------------
module wsr_datapath #(
  parameter int MAX_LENGTH   = wsr_pkg::MAX_LENGTH_DEF,
  parameter int SAMPLE_WIDTH = wsr_pkg::SAMPLE_WIDTH_DEF
) (
  input  logic                              clk,
  input  logic                              rst,
  input  wsr_pkg::wsr_cmd_t                 cmd,
  output wsr_pkg::wsr_stat_t                stat,
  input  logic [wsr_pkg::IDX_W-1:0]         coef_index,
  input  logic signed [wsr_pkg::VAL_W-1:0]  value_real,
  input  logic signed [wsr_pkg::VAL_W-1:0]  value_imag,
  wsr_cfg_if.sink                           cfg,
  wsr_result_if.source                      result
);
  import wsr_pkg::*;

  localparam int AW    = $clog2(MAX_LENGTH);
  localparam int PW    = (AW + 1 > FLEN_W) ? AW + 1 : FLEN_W;
  localparam int SW    = SAMPLE_WIDTH;
  localparam int PRODW = SW + VAL_W;
  localparam int ACC_W = SW + VAL_W + 2 + AW;

  // configuration
  logic [FLEN_W-1:0] frame_length;
  assign cfg.ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      frame_length <= FLEN_RESET;
    end else if (cfg.valid) begin
      frame_length <= cfg.frame_length;
    end
  end

  // frame position
  logic [PW-1:0] fl_ext, len, pos, pp, cur_p, tap, kidx, ci_ext;
  logic          last_q;

  assign fl_ext = PW'(frame_length);
  assign len    = (fl_ext == '0) ? PW'(1) :
                  (fl_ext > PW'(MAX_LENGTH)) ? PW'(MAX_LENGTH) : fl_ext;
  assign pp     = (pos >= len) ? '0 : pos;
  assign ci_ext = PW'(coef_index);
  assign kidx   = cur_p - tap;

  always_ff @(posedge clk) begin
    if (rst) begin
      pos <= '0;
    end else if (cmd.start_sample) begin
      pos <= (pp + 1'b1 >= len) ? '0 : pp + 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.start_sample) begin
      cur_p  <= pp;
      last_q <= (pp == len - 1'b1);
      tap    <= '0;
    end else if (cmd.issue) begin
      tap <= tap + 1'b1;
    end
  end

  assign stat.last_tap = (tap == cur_p);

  // sample extension: narrow samples take the low bits, wide ones the raw field zero-extended
  logic [SW-1:0] xs_re, xs_im;
  generate
    if (SW <= VAL_W) begin : g_narrow
      assign xs_re = value_real[SW-1:0];
      assign xs_im = value_imag[SW-1:0];
    end else begin : g_wide
      assign xs_re = SW'(unsigned'(value_real));
      assign xs_im = SW'(unsigned'(value_imag));
    end
  endgenerate

  logic [2*VAL_W-1:0] coef_rd;
  logic [2*SW-1:0]    hist_rd;

  wsr_ram #(.WIDTH(2 * VAL_W), .DEPTH(MAX_LENGTH)) u_coef_ram (
    .clk   (clk),
    .we    (cmd.load_coef && (ci_ext < PW'(MAX_LENGTH))),
    .waddr (ci_ext[AW-1:0]),
    .wdata ({value_imag, value_real}),
    .raddr (kidx[AW-1:0]),
    .rdata (coef_rd)
  );

  wsr_ram #(.WIDTH(2 * SW), .DEPTH(MAX_LENGTH)) u_hist_ram (
    .clk   (clk),
    .we    (cmd.start_sample),
    .waddr (pp[AW-1:0]),
    .wdata ({xs_im, xs_re}),
    .raddr (tap[AW-1:0]),
    .rdata (hist_rd)
  );

  // complex mac: ram read, multiply, accumulate
  logic                    v1, v2;
  logic signed [SW-1:0]    xr, xi;
  logic signed [VAL_W-1:0] wr, wi;
  logic signed [PRODW-1:0] prr, pii, pri, pir;
  logic signed [ACC_W-1:0] acc_re, acc_im;

  assign xr = signed'(hist_rd[SW-1:0]);
  assign xi = signed'(hist_rd[2*SW-1:SW]);
  assign wr = signed'(coef_rd[VAL_W-1:0]);
  assign wi = signed'(coef_rd[2*VAL_W-1:VAL_W]);

  always_ff @(posedge clk) begin
    if (rst) begin
      v1 <= 1'b0;
      v2 <= 1'b0;
    end else begin
      v1 <= cmd.issue;
      v2 <= v1;
    end
  end

  always_ff @(posedge clk) begin
    prr <= xr * wr;
    pii <= xi * wi;
    pri <= xr * wi;
    pir <= xi * wr;
    if (cmd.start_sample) begin
      acc_re <= '0;
      acc_im <= '0;
    end else if (v2) begin
      acc_re <= acc_re + ACC_W'(prr) - ACC_W'(pii);
      acc_im <= acc_im + ACC_W'(pri) + ACC_W'(pir);
    end
  end

  // floor shift, absolute value, clip
  logic signed [ACC_W-1:0] sh_re, sh_im, abs_re, abs_im;
  logic [MAG_W-1:0]        part_re, part_im;
  logic                    sat;

  assign sh_re  = acc_re >>> FRAC_BITS;
  assign sh_im  = acc_im >>> FRAC_BITS;
  assign abs_re = sh_re[ACC_W-1] ? -sh_re : sh_re;
  assign abs_im = sh_im[ACC_W-1] ? -sh_im : sh_im;

  logic [2*MAG_W-1:0] sq_re, sq_im;
  logic [RAD_W-1:0]   rad;
  logic [REM_W-1:0]   rem, rem_sh, trial;
  logic [ROOT_STEPS-1:0] root;

  assign rem_sh = {rem[REM_W-3:0], rad[RAD_W-1:RAD_W-2]};
  assign trial  = REM_W'({root, 2'b01});

  always_ff @(posedge clk) begin
    if (cmd.parts) begin
      part_re <= abs_re[MAG_W-1:0];
      part_im <= abs_im[MAG_W-1:0];
      sat     <= (abs_re > ACC_W'(MAG_MAX)) || (abs_im > ACC_W'(MAG_MAX));
    end
    if (cmd.square) begin
      sq_re <= part_re * part_re;
      sq_im <= part_im * part_im;
    end
    if (cmd.sum) begin
      rad  <= RAD_W'(sq_re) + RAD_W'(sq_im);
      rem  <= '0;
      root <= '0;
    end else if (cmd.root_step) begin
      rad <= {rad[RAD_W-3:0], 2'b00};
      if (rem_sh >= trial) begin
        rem  <= rem_sh - trial;
        root <= {root[ROOT_STEPS-2:0], 1'b1};
      end else begin
        rem  <= rem_sh;
        root <= {root[ROOT_STEPS-2:0], 1'b0};
      end
    end
  end

  // result register
  assign stat.out_free = !result.valid || result.ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      result.valid <= 1'b0;
    end else if (cmd.load_out) begin
      result.valid <= 1'b1;
    end else if (result.ready) begin
      result.valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load_out) begin
      result.magnitude       <= (sat || root[ROOT_STEPS-1]) ? MAG_MAX
                                                            : root[MAG_W-1:0];
      result.sample_position <= cur_p[POS_W-1:0];
      result.frame_last      <= last_q;
    end
  end
endmodule

### sv/wavelet_scalogram_row_top.sv
// ---------------------------------------------------------------------------
// wavelet scalogram row top
// one frequency row of a morlet scalogram: complex fir over the frame,
// then integer magnitude of the shifted sum
// ---------------------------------------------------------------------------
//  channel  dir  beat carries
//  item     in   cmd, coef_index, value_real, value_imag
//  result   out  magnitude, sample_position, frame_last
//  cfg      in   frame_length
//
// a load beat leaves the block idle; a sample at frame position p runs through
// accept, p + 1 taps through one complex mac, drain, magnitude prep (parts, square,
// sum), 27 root steps and hand-off; p reaches at most 1023
// the result register frees the input while a result waits; the next sample
// finishes only once that result is taken
// synchronous reset clears control, frame position and frame_length to 1000
`include "wavelet_scalogram_row_top_defines.svh"

module wavelet_scalogram_row_top #(
  parameter int MAX_LENGTH   = wsr_pkg::MAX_LENGTH_DEF,
  parameter int SAMPLE_WIDTH = wsr_pkg::SAMPLE_WIDTH_DEF
) (
  input logic          clk,
  input logic          rst,
  wsr_item_if.sink     item,
  wsr_result_if.source result,
  wsr_cfg_if.sink      cfg
);
  import wsr_pkg::*;

  wsr_cmd_t  cmd;
  wsr_stat_t stat;
  logic      in_ready;

  assign item.ready = in_ready;

  wsr_ctrl u_ctrl (
    .clk          (clk),
    .rst          (rst),
    .in_valid     (item.valid),
    .in_is_sample (item.cmd == CMD_SAMPLE),
    .stat         (stat),
    .in_ready     (in_ready),
    .cmd          (cmd)
  );

  wsr_datapath #(
    .MAX_LENGTH   (MAX_LENGTH),
    .SAMPLE_WIDTH (SAMPLE_WIDTH)
  ) u_datapath (
    .clk        (clk),
    .rst        (rst),
    .cmd        (cmd),
    .stat       (stat),
    .coef_index (item.coef_index),
    .value_real (item.value_real),
    .value_imag (item.value_imag),
    .cfg        (cfg),
    .result     (result)
  );

  `WSR_ASSERT_SAME(a_load_out_free, clk, rst, cmd.load_out, stat.out_free, "result overwritten")
  `WSR_ASSERT_NEXT(a_busy_after_sample, clk, rst, item.valid && item.ready && item.cmd == CMD_SAMPLE, !item.ready, "input open during sample")
  `WSR_ASSERT_NEXT(a_taps_stop, clk, rst, cmd.issue && stat.last_tap, !cmd.issue, "tap issued past last")
endmodule
